[hw/rtl/assert_macros.svh]
// assertion macros shared by the frame filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bcff_pkg.sv]
// shared types, codes and constants of the command frame filter
package bcff_pkg;

    localparam int MAC_W        = 48;
    localparam int GROUP_LEN_W  = 4;
    localparam int LED_BYTES    = 6;

    // frame layout
    localparam logic [7:0] HEADER_BYTES    = 8'd4;
    localparam logic [7:0] CMD_POS         = 8'd4;
    localparam logic [7:0] PAYLOAD_START   = 8'd5;
    localparam logic [7:0] POS_SAT         = 8'd255;
    localparam logic [7:0] MAC_BYTES       = 8'd6;
    localparam logic [7:0] LED_SPAN        = 8'd6;
    localparam logic [7:0] UNICAST_LEN     = 8'd12;
    localparam logic [7:0] UNICAST_LED_OFF = 8'd6;
    localparam logic [7:0] PREFIX_BYTES    = 8'd4;
    localparam logic [7:0] GROUP_LEN_BIAS  = 8'd4;
    localparam int         MIN_GROUP_BYTES = 6;

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'hb0, 8'h1b, 8'hca, 8'h57};

    // command codes
    localparam logic [7:0] CMD_UNICAST_LED = 8'h20;
    localparam logic [7:0] CMD_ASSIGN_LO   = 8'h32;
    localparam logic [7:0] CMD_ASSIGN_HI   = 8'h38;
    localparam logic [7:0] CMD_GROUP_LED   = 8'h40;
    localparam logic [7:0] CMD_RESTART     = 8'h50;
    localparam logic [7:0] CMD_LEN_MASK    = 8'h0f;

    // decision codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_NONE    = 2'd0;
    localparam action_t ACT_SET_LED = 2'd1;
    localparam action_t ACT_RESTART = 2'd2;
    localparam action_t ACT_ASSIGN  = 2'd3;

    typedef struct packed {
        logic header_ok;
        logic unicast_ok;
        logic prefix_ok;
        logic mask_ok;
    } frame_flags_t;

    localparam frame_flags_t FLAGS_CLEAR = '{
        header_ok:  1'b1,
        unicast_ok: 1'b1,
        prefix_ok:  1'b1,
        mask_ok:    1'b0
    };

    typedef struct packed {
        action_t                action;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [7:0]             white;
        logic [15:0]            fade_time;
        logic [GROUP_LEN_W-1:0] group_length;
    } result_t;

    // own address byte k, byte 0 is the most significant
    function automatic logic [7:0] mac_byte(logic [MAC_W-1:0] mac, logic [2:0] k);
        logic [7:0] sel;
        unique case (k)
            3'd0:    sel = mac[47:40];
            3'd1:    sel = mac[39:32];
            3'd2:    sel = mac[31:24];
            3'd3:    sel = mac[23:16];
            3'd4:    sel = mac[15:8];
            3'd5:    sel = mac[7:0];
            default: sel = 8'h00;
        endcase
        return sel;
    endfunction

endpackage

[hw/rtl/bcff_channel_if.sv]
// valid/ready channels for frame bytes and decisions
interface bcff_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bcff_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic [15:0] fade_time;
    logic [3:0]  group_length;

    modport source (output valid, output action, output red, output green, output blue,
                    output white, output fade_time, output group_length, input ready);
    modport sink   (input valid, input action, input red, input green, input blue,
                    input white, input fade_time, input group_length, output ready);
endinterface

[hw/rtl/bcff_decide.sv]
// end-of-frame decision from the per-frame match flags
module bcff_decide #(
    parameter int MAX_GROUP_BYTES    = 12,
    parameter int PAYLOAD_KEEP_BYTES = 18
) (
    input  logic [7:0]                               pos,
    input  logic [7:0]                               cmd,
    input  bcff_pkg::frame_flags_t                   flags,
    input  logic [$clog2(MAX_GROUP_BYTES+1)-1:0]     group_size,
    output bcff_pkg::action_t                        action,
    output logic [$clog2(MAX_GROUP_BYTES+1)-1:0]     assign_len
);
    import bcff_pkg::*;

    localparam int GSZ_W = $clog2(MAX_GROUP_BYTES + 1);

    logic [7:0] n;
    logic [7:0] alen;
    logic [7:0] gs8;
    logic       is_assign;
    logic       member;
    logic       hdr_ok;

    // payload length, assign length and group membership
    assign n         = pos - CMD_POS;
    assign alen      = (cmd & CMD_LEN_MASK) + GROUP_LEN_BIAS;
    assign gs8       = 8'(group_size);
    assign is_assign = (cmd >= CMD_ASSIGN_LO) && (cmd <= CMD_ASSIGN_HI);
    assign hdr_ok    = flags.header_ok && (pos >= CMD_POS);
    assign member    = (gs8 != 8'd0) && (n >= gs8) && flags.prefix_ok && flags.mask_ok;
    assign assign_len = alen[GSZ_W-1:0];

    // command dispatch
    always_comb
    begin
        action = ACT_NONE;
        if (hdr_ok)
        begin
            priority if (cmd == CMD_UNICAST_LED)
            begin
                if (n == UNICAST_LEN && flags.unicast_ok)
                    action = ACT_SET_LED;
            end
            else if (is_assign)
            begin
                if (n >= alen + MAC_BYTES && flags.unicast_ok &&
                    alen <= 8'(MAX_GROUP_BYTES) && alen <= 8'(PAYLOAD_KEEP_BYTES))
                    action = ACT_ASSIGN;
            end
            else if (cmd == CMD_GROUP_LED)
            begin
                if (member && n >= gs8 + LED_SPAN &&
                    gs8 + LED_SPAN <= 8'(PAYLOAD_KEEP_BYTES))
                    action = ACT_SET_LED;
            end
            else if (cmd == CMD_RESTART)
            begin
                if (member)
                    action = ACT_RESTART;
            end
            else
            begin
                // unknown command
                action = ACT_NONE;
            end
        end
    end

endmodule

[hw/rtl/ble_command_frame_filter_unit.sv]
// Command frame filter: one frame byte per cycle, one decision per frame.
// Throughput: one byte accepted every cycle, also across frame ends, while the
// result register is free or being drained in the same cycle.
// After the last-byte transfer the decision passes through the input register,
// then the per-byte match logic feeding the result register.
// Reset clears the own address, frame tracking, group length and both valid flags.
`include "assert_macros.svh"

module ble_command_frame_filter_unit #(
    parameter int MAX_GROUP_BYTES    = 12,
    parameter int PAYLOAD_KEEP_BYTES = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bcff_in_if.sink                    frame_in,
    bcff_out_if.source                 decision_out,
    input  logic                       cfg_wr_en,
    input  logic [bcff_pkg::MAC_W-1:0] cfg_wr_data
);
    import bcff_pkg::*;

    localparam int GIDX_W = (MAX_GROUP_BYTES > 1) ? $clog2(MAX_GROUP_BYTES) : 1;
    localparam int GSZ_W  = $clog2(MAX_GROUP_BYTES + 1);

    // registers
    logic [MAC_W-1:0] mac_reg;
    logic             s_vld_reg;
    logic [7:0]       s_byte_reg;
    logic             s_last_reg;
    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       cmd_reg, cmd_next;
    frame_flags_t     flags_reg, flags_next;
    logic [7:0]       pay_reg  [MAX_GROUP_BYTES];
    logic [7:0]       pay_next [MAX_GROUP_BYTES];
    logic [7:0]       grp_reg  [MAX_GROUP_BYTES];
    logic [7:0]       grp_next [MAX_GROUP_BYTES];
    logic [7:0]       led_reg  [LED_BYTES];
    logic [7:0]       led_next [LED_BYTES];
    logic [GSZ_W-1:0] gsize_reg, gsize_next;
    logic             out_vld_reg;
    result_t          out_reg, out_next;

    logic             fire;
    logic             frame_end;
    logic             out_free;
    logic [7:0]       p;
    logic             is_uni;
    logic             is_asg;
    logic [7:0]       mac_off;
    logic [7:0]       mac_k;
    logic [7:0]       led_off;
    logic [7:0]       grp_rd;
    action_t          dec_action;
    logic [GSZ_W-1:0] dec_len;

    // handshake: input register advances unless a frame end meets a full result register
    assign out_free       = !out_vld_reg || decision_out.ready;
    assign fire           = s_vld_reg && (!s_last_reg || out_free);
    assign frame_end      = fire && s_last_reg;
    assign frame_in.ready = !s_vld_reg || fire;

    // byte position decode
    assign p       = pos_reg - PAYLOAD_START;
    assign is_uni  = (cmd_reg == CMD_UNICAST_LED);
    assign is_asg  = (cmd_reg >= CMD_ASSIGN_LO) && (cmd_reg <= CMD_ASSIGN_HI);
    assign mac_off = is_uni ? 8'd0 : (cmd_reg & CMD_LEN_MASK) + GROUP_LEN_BIAS;
    assign mac_k   = p - mac_off;
    assign led_off = (cmd_reg == CMD_UNICAST_LED) ? UNICAST_LED_OFF : 8'(gsize_reg);
    assign grp_rd  = grp_reg[p[GIDX_W-1:0]];

    // per-byte state update
    always_comb
    begin
        cmd_next   = cmd_reg;
        flags_next = flags_reg;
        pay_next   = pay_reg;
        led_next   = led_reg;
        if (pos_reg < HEADER_BYTES)
        begin
            if (s_byte_reg != MAGIC_BYTES[pos_reg[1:0]])
                flags_next.header_ok = 1'b0;
        end
        else if (pos_reg == CMD_POS)
        begin
            cmd_next = s_byte_reg;
        end
        else if (pos_reg != POS_SAT)
        begin
            // payload bytes kept for a later group copy
            for (int i = 0; i < MAX_GROUP_BYTES; i++)
            begin
                if (p == 8'(i) && p < 8'(PAYLOAD_KEEP_BYTES))
                    pay_next[i] = s_byte_reg;
            end
            // own address check
            if ((is_uni || is_asg) && p >= mac_off && p < mac_off + MAC_BYTES &&
                s_byte_reg != mac_byte(mac_reg, mac_k[2:0]))
                flags_next.unicast_ok = 1'b0;
            // stored group: prefix equality, then any shared mask bit
            if (p < 8'(gsize_reg) && p < 8'(MAX_GROUP_BYTES))
            begin
                if (p < PREFIX_BYTES)
                begin
                    if (grp_rd != s_byte_reg)
                        flags_next.prefix_ok = 1'b0;
                end
                else if ((grp_rd & s_byte_reg) != 8'd0)
                begin
                    flags_next.mask_ok = 1'b1;
                end
            end
            // led bytes captured at their offset
            for (int k = 0; k < LED_BYTES; k++)
            begin
                if (p == led_off + 8'(k) && p < 8'(PAYLOAD_KEEP_BYTES))
                    led_next[k] = s_byte_reg;
            end
        end
        pos_next = (pos_reg != POS_SAT) ? pos_reg + 8'd1 : pos_reg;
    end

    bcff_decide #(
        .MAX_GROUP_BYTES    (MAX_GROUP_BYTES),
        .PAYLOAD_KEEP_BYTES (PAYLOAD_KEEP_BYTES)
    ) u_decide (
        .pos        (pos_reg),
        .cmd        (cmd_next),
        .flags      (flags_next),
        .group_size (gsize_reg),
        .action     (dec_action),
        .assign_len (dec_len)
    );

    // group store and result assembly
    always_comb
    begin
        gsize_next = (dec_action == ACT_ASSIGN) ? dec_len : gsize_reg;
        for (int i = 0; i < MAX_GROUP_BYTES; i++)
        begin
            if (dec_action == ACT_ASSIGN && 8'(i) < 8'(dec_len))
                grp_next[i] = pay_next[i];
            else
                grp_next[i] = grp_reg[i];
        end
        out_next.action       = dec_action;
        out_next.red          = '0;
        out_next.green        = '0;
        out_next.blue         = '0;
        out_next.white        = '0;
        out_next.fade_time    = '0;
        out_next.group_length = GROUP_LEN_W'(gsize_next);
        if (dec_action == ACT_SET_LED)
        begin
            out_next.red       = led_next[0];
            out_next.green     = led_next[1];
            out_next.blue      = led_next[2];
            out_next.white     = led_next[3];
            out_next.fade_time = {led_next[5], led_next[4]};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg     <= '0;
            s_vld_reg   <= 1'b0;
            pos_reg     <= '0;
            cmd_reg     <= '0;
            flags_reg   <= FLAGS_CLEAR;
            gsize_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mac_reg <= cfg_wr_data;
            if (frame_in.ready)
                s_vld_reg <= frame_in.valid;
            if (frame_end)
            begin
                pos_reg   <= '0;
                cmd_reg   <= '0;
                flags_reg <= FLAGS_CLEAR;
                gsize_reg <= gsize_next;
            end
            else if (fire)
            begin
                pos_reg   <= pos_next;
                cmd_reg   <= cmd_next;
                flags_reg <= flags_next;
            end
            if (frame_end)
                out_vld_reg <= 1'b1;
            else if (decision_out.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (frame_in.ready && frame_in.valid)
        begin
            s_byte_reg <= frame_in.byte_value;
            s_last_reg <= frame_in.last_byte;
        end
        if (fire)
        begin
            pay_reg <= pay_next;
            led_reg <= led_next;
        end
        if (frame_end)
        begin
            grp_reg <= grp_next;
            out_reg <= out_next;
        end
    end

    // result channel
    assign decision_out.valid        = out_vld_reg;
    assign decision_out.action       = out_reg.action;
    assign decision_out.red          = out_reg.red;
    assign decision_out.green        = out_reg.green;
    assign decision_out.blue         = out_reg.blue;
    assign decision_out.white        = out_reg.white;
    assign decision_out.fade_time    = out_reg.fade_time;
    assign decision_out.group_length = out_reg.group_length;

    // checks
    `ASSERT_CLK(a_group_size_legal, (gsize_reg == '0) || (gsize_reg >= MIN_GROUP_BYTES && gsize_reg <= MAX_GROUP_BYTES), "group size outside legal range")
    `ASSERT_NEXT(a_frame_state_cleared, frame_end, pos_reg == '0 && cmd_reg == '0 && flags_reg == FLAGS_CLEAR, "frame state not cleared after last byte")
    `ASSERT_NEXT(a_pos_step, fire && !s_last_reg && pos_reg != POS_SAT, pos_reg == $past(pos_reg) + 8'd1, "byte position did not advance")
    `ASSERT_CLK(a_blank_levels, (decision_out.valid && decision_out.action != ACT_SET_LED) |-> (decision_out.red == '0 && decision_out.green == '0 && decision_out.blue == '0 && decision_out.white == '0 && decision_out.fade_time == '0), "led levels set without led action")

endmodule
